FILE: hw/rtl/cau_pkg.sv
`default_nettype none
package cau_pkg;
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;
endpackage
`default_nettype wire

FILE: hw/rtl/cau_if.sv
`default_nettype none
interface cau_in_if #(parameter int DATA_WIDTH = 16) (input wire logic i_clk);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
    modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int DATA_WIDTH = 16) (input wire logic i_clk);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    logic                         overflow;
    logic                         div_by_zero;
    modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
    modport sink (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/cau_divider.sv
`default_nettype none
// Pipelined restoring divider, one quotient bit per stage.
// Quotient of num/den in QW bits; o_sat flags a quotient wider than QW bits.
module cau_divider #(
    parameter int NW = 48,
    parameter int DW = 33,
    parameter int QW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic      [QW-1:0] o_quo,
    output logic               o_sat
);
    // num >> (QW) >= den means the quotient exceeds QW bits
    logic [QW-1:0] r_num [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [DW:0]   r_rem [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_sat [QW+1];
    logic [NW:0]   w_hi;

    assign w_hi = {1'b0, i_num} >> QW;

    // start from the upper part of num; the low QW bits shift in one per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_rem[0] <= w_hi[DW:0];
            r_quo[0] <= '0;
            r_sat[0] <= (w_hi >= {{(NW+1-DW){1'b0}}, i_den});
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW+1:0] w_t;
        logic          w_ge;
        assign w_t  = {r_rem[g], r_num[g][QW-1]};
        assign w_ge = (w_t >= {2'b00, r_den[g]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g+1] <= r_num[g] << 1;
                r_den[g+1] <= r_den[g];
                r_rem[g+1] <= w_ge ? w_t[DW:0] - {1'b0, r_den[g]} : w_t[DW:0];
                r_quo[g+1] <= {r_quo[g][QW-2:0], w_ge};
                r_sat[g+1] <= r_sat[g];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_sat = r_sat[QW];
endmodule
`default_nettype wire

FILE: hw/rtl/complex_arith_unit.sv
`default_nettype none
// All operations share one pipeline from input beat to output beat, its depth set by the
// one-bit-per-stage quotient pipeline.
// Throughput: one beat per cycle; the whole pipeline holds while the output stalls.
// Reset: i_rst_n synchronous active low clears all valid bits; data is not reset.
module complex_arith_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    cau_in_if.sink   i_in,
    cau_out_if.source o_out
);
    import cau_pkg::*;
    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;          // product magnitude width
    localparam int SW = PW + 1;         // sum of two products
    localparam int NW = SW + FRAC_BITS; // shifted numerator
    localparam int LAT = W + 4;
    localparam logic [W-1:0] LIM = {1'b1, {(W-1){1'b0}}};

    logic          w_en;
    logic [LAT-1:0] r_vld;

    // stage 0 registers: magnitudes, signs and add/sub sums
    t_op         r0_op;
    logic [W-1:0] r0_mar, r0_mai, r0_mbr, r0_mbi;
    logic        r0_sar, r0_sai, r0_sbr, r0_sbi;
    logic signed [W:0] r0_s_re, r0_s_im;

    // stage 1: products
    t_op          r1_op;
    logic [PW-1:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir, r1_p_bb, r1_p_cc;
    logic         r1_s_rr, r1_s_ii, r1_s_ri, r1_s_ir;
    logic signed [W:0] r1_s_re, r1_s_im;

    // stage 2: signed sums and denominator
    t_op          r2_op;
    logic [SW-1:0] r2_m1, r2_m2, r2_den;
    logic         r2_s1, r2_s2;
    logic signed [W:0] r2_s_re, r2_s_im;

    // divider side channel, delayed to match
    t_op           r_op_d  [W+1];
    logic [SW-1:0]  r_m1_d  [W+1];
    logic [SW-1:0]  r_m2_d  [W+1];
    logic          r_s1_d  [W+1];
    logic          r_s2_d  [W+1];
    logic          r_dz_d  [W+1];
    logic signed [W:0] r_sre_d [W+1];
    logic signed [W:0] r_sim_d [W+1];

    logic [W-1:0]  w_q1, w_q2;
    logic          w_qs1, w_qs2;

    // output register
    logic          r_o_vld;
    logic [W-1:0]  r_o_re, r_o_im;
    logic          r_o_ovf, r_o_dz;

    assign o_out.valid = r_o_vld;
    assign i_in.ready  = w_en;
    assign w_en        = !r_o_vld || o_out.ready;
    assign o_out.res_re      = r_o_re;
    assign o_out.res_im      = r_o_im;
    assign o_out.overflow    = r_o_ovf;
    assign o_out.div_by_zero = r_o_dz;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_op  <= t_op'(i_in.op);
            r0_mar <= f_mag(i_in.a_re);
            r0_mai <= f_mag(i_in.a_im);
            r0_mbr <= f_mag(i_in.b_re);
            r0_mbi <= f_mag(i_in.b_im);
            r0_sar <= i_in.a_re[W-1];
            r0_sai <= i_in.a_im[W-1];
            r0_sbr <= i_in.b_re[W-1];
            r0_sbi <= i_in.b_im[W-1];
            r0_s_re <= (i_in.op == OP_SUB) ? (W+1)'(i_in.a_re) - (W+1)'(i_in.b_re)
                                           : (W+1)'(i_in.a_re) + (W+1)'(i_in.b_re);
            r0_s_im <= (i_in.op == OP_SUB) ? (W+1)'(i_in.a_im) - (W+1)'(i_in.b_im)
                                           : (W+1)'(i_in.a_im) + (W+1)'(i_in.b_im);

            r1_op   <= r0_op;
            r1_p_rr <= PW'(r0_mar) * PW'(r0_mbr);
            r1_p_ii <= PW'(r0_mai) * PW'(r0_mbi);
            r1_p_ri <= PW'(r0_mar) * PW'(r0_mbi);
            r1_p_ir <= PW'(r0_mai) * PW'(r0_mbr);
            r1_p_bb <= PW'(r0_mbr) * PW'(r0_mbr);
            r1_p_cc <= PW'(r0_mbi) * PW'(r0_mbi);
            r1_s_rr <= r0_sar ^ r0_sbr;
            r1_s_ii <= r0_sai ^ r0_sbi;
            r1_s_ri <= r0_sar ^ r0_sbi;
            r1_s_ir <= r0_sai ^ r0_sbr;
            r1_s_re <= r0_s_re;
            r1_s_im <= r0_s_im;
        end
    end

    // sign-magnitude add
    function automatic logic [SW:0] f_sm(input logic s1, input logic [PW-1:0] m1,
                                         input logic s2, input logic [PW-1:0] m2);
        logic [SW-1:0] a, b;
        a = SW'(m1);
        b = SW'(m2);
        if (s1 == s2) return {s1, a + b};
        else if (a >= b) return {s1, a - b};
        else return {s2, b - a};
    endfunction

    logic [SW:0] w_sm1, w_sm2;
    always_comb begin
        if (r1_op == OP_MUL) begin
            w_sm1 = f_sm(r1_s_rr, r1_p_rr, !r1_s_ii, r1_p_ii);
            w_sm2 = f_sm(r1_s_ri, r1_p_ri, r1_s_ir, r1_p_ir);
        end else begin
            w_sm1 = f_sm(r1_s_rr, r1_p_rr, r1_s_ii, r1_p_ii);
            w_sm2 = f_sm(r1_s_ir, r1_p_ir, !r1_s_ri, r1_p_ri);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_op   <= r1_op;
            r2_s1   <= w_sm1[SW];
            r2_m1   <= w_sm1[SW-1:0];
            r2_s2   <= w_sm2[SW];
            r2_m2   <= w_sm2[SW-1:0];
            r2_den  <= SW'(r1_p_bb) + SW'(r1_p_cc);
            r2_s_re <= r1_s_re;
            r2_s_im <= r1_s_im;
        end
    end

    logic [SW-1:0] w_dsafe;
    assign w_dsafe = (r2_den == '0) ? SW'(1) : r2_den;

    cau_divider #(.NW(NW), .DW(SW), .QW(W)) u_div_re (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (NW'(r2_m1) << FRAC_BITS), .i_den (w_dsafe),
        .o_quo (w_q1), .o_sat (w_qs1)
    );
    cau_divider #(.NW(NW), .DW(SW), .QW(W)) u_div_im (
        .i_clk (i_clk), .i_en (w_en),
        .i_num (NW'(r2_m2) << FRAC_BITS), .i_den (w_dsafe),
        .o_quo (w_q2), .o_sat (w_qs2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op_d[0]  <= r2_op;
            r_m1_d[0]  <= r2_m1;
            r_m2_d[0]  <= r2_m2;
            r_s1_d[0]  <= r2_s1;
            r_s2_d[0]  <= r2_s2;
            r_dz_d[0]  <= (r2_den == '0);
            r_sre_d[0] <= r2_s_re;
            r_sim_d[0] <= r2_s_im;
            for (int k = 0; k < W; k++) begin
                r_op_d[k+1]  <= r_op_d[k];
                r_m1_d[k+1]  <= r_m1_d[k];
                r_m2_d[k+1]  <= r_m2_d[k];
                r_s1_d[k+1]  <= r_s1_d[k];
                r_s2_d[k+1]  <= r_s2_d[k];
                r_dz_d[k+1]  <= r_dz_d[k];
                r_sre_d[k+1] <= r_sre_d[k];
                r_sim_d[k+1] <= r_sim_d[k];
            end
        end
    end

    // saturate sign-magnitude; returns {ovf, bits}
    function automatic logic [W:0] f_sat(input logic neg, input logic big,
                                         input logic [W-1:0] mag);
        if (neg) begin
            if (big || mag > LIM) return {1'b1, LIM};
            return {1'b0, ~mag + 1'b1};
        end
        if (big || mag > LIM - 1'b1) return {1'b1, LIM - 1'b1};
        return {1'b0, mag};
    endfunction

    function automatic logic [W:0] f_sat_s(input logic signed [W:0] v);
        logic [W:0] m;
        m = v[W] ? (~v + 1'b1) : v;
        return f_sat(v[W], m[W], m[W-1:0]);
    endfunction

    logic [SW-1:0] w_sh1, w_sh2;
    logic [W:0]    w_re, w_im;
    assign w_sh1 = r_m1_d[W] >> FRAC_BITS;
    assign w_sh2 = r_m2_d[W] >> FRAC_BITS;

    always_comb begin
        unique case (r_op_d[W])
            OP_ADD, OP_SUB: begin
                w_re = f_sat_s(r_sre_d[W]);
                w_im = f_sat_s(r_sim_d[W]);
            end
            OP_MUL: begin
                w_re = f_sat(r_s1_d[W], |w_sh1[SW-1:W], w_sh1[W-1:0]);
                w_im = f_sat(r_s2_d[W], |w_sh2[SW-1:W], w_sh2[W-1:0]);
            end
            default: begin
                if (r_dz_d[W]) begin
                    w_re = '0;
                    w_im = '0;
                end else begin
                    w_re = f_sat(r_s1_d[W], w_qs1, w_q1);
                    w_im = f_sat(r_s2_d[W], w_qs2, w_q2);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_vld   <= {r_vld[LAT-2:0], i_in.valid};
            r_o_vld <= r_vld[LAT-1];
        end
        if (w_en) begin
            r_o_re  <= w_re[W-1:0];
            r_o_im  <= w_im[W-1:0];
            r_o_ovf <= w_re[W] | w_im[W];
            r_o_dz  <= (r_op_d[W] == OP_DIV) && r_dz_d[W];
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !o_out.ready) |=> (r_o_vld && $stable(r_o_re) && $stable(r_o_im)))
        else $error("output beat changed under stall");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_dz) |-> (r_o_re == '0 && r_o_im == '0 && !r_o_ovf))
        else $error("divide by zero result not clean");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en) |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
endmodule
`default_nettype wire
